// ===== hw/rtl/lrt_pkg.sv =====
// Shared types and constants for the LRU residency tracker.
package lrt_pkg;

    // Fixed field widths of the request and result transfers and the register port
    localparam int ID_W   = 10;
    localparam int OCC_W  = 7;
    localparam int CAP_W  = 7;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 1;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [CAP_W-1:0]  cap_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Request opcodes
    localparam logic OP_TOUCH  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Register map
    localparam addr_t CAP_ADDR  = '0;
    localparam cap_t  CAP_RESET = cap_t'(4 * 4 * 4);

    typedef struct packed {
        logic opcode;
        id_t  item_id;
    } lrt_req_t;

    typedef struct packed {
        logic hit;
        logic evict_valid;
        id_t  evicted_id;
        occ_t occupancy;
    } lrt_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lrt_state_t;

endpackage

// ===== hw/rtl/lrt_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
module lrt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/lrt_cfg.sv =====
// Capacity register behind the APB port, with clamping to the list depth.
module lrt_cfg #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  lrt_pkg::addr_t                paddr,
    input  lrt_pkg::data_t                pwdata,
    output lrt_pkg::data_t                prdata,
    output logic                          pready,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] eff_cap
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EW    = (CNT_W > lrt_pkg::CAP_W) ? CNT_W : lrt_pkg::CAP_W;

    lrt_pkg::cap_t cap_reg;
    lrt_pkg::cap_t cap_next;
    logic [EW-1:0] cap_w;
    logic [EW-1:0] max_w;

    assign pready = 1'b1;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && (paddr == lrt_pkg::CAP_ADDR))
        begin
            cap_next = pwdata[lrt_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lrt_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata = (paddr == lrt_pkg::CAP_ADDR) ? lrt_pkg::data_t'(cap_reg) : '0;

    // Zero acts as one, anything above the depth saturates
    assign cap_w = EW'(cap_reg);
    assign max_w = EW'(MAX_ENTRIES);

    always_comb
    begin
        priority if (cap_w == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_w > max_w)
        begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(cap_w);
        end
    end

endmodule

// ===== hw/rtl/lru_residency_tracker.sv =====
// Top level of the LRU residency tracker: request sequencer around the list RAM.
//
// Usage:
//   Request channel: drive req (opcode, item_id) and raise start; the transfer
//   happens at a rising edge where start is high and busy is low. busy stays
//   high until the request has been fully worked.
//   Result channel: done pulses for one cycle with rsp (hit, evict_valid,
//   evicted_id, occupancy). The receiver cannot stall; the result must be
//   taken in that cycle. busy is already low in the cycle done is high, so
//   the next request may be transferred then.
//   Timing: the recency list lives in one RAM with a registered read,
//   scanned one entry per cycle from the front. A touch that hits stops
//   its scan at the hit position; any other request scans the resident
//   count, none on an empty list. Touches shift entries down as they
//   scan; removes close the gap behind the match. A final state appends
//   or evicts at the tail.
//   Configuration: capacity at APB byte address 0; write only while idle.
//   Reset: rst_n clears the resident count to zero and capacity to 64.
//   No clearing pass is needed; list entries beyond the count are never used.
module lru_residency_tracker #(
    parameter int MAX_ENTRIES = 64,
    parameter int ID_BITS     = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    // request transfer
    input  logic               start,
    output logic               busy,
    input  lrt_pkg::lrt_req_t  req,
    // result transfer
    output logic               done,
    output lrt_pkg::lrt_rsp_t  rsp,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  lrt_pkg::addr_t     paddr,
    input  lrt_pkg::data_t     pwdata,
    output lrt_pkg::data_t     prdata,
    output logic               pready
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    lrt_pkg::lrt_state_t state_reg, state_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               op_reg, op_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [ID_BITS-1:0] carry_reg, carry_next;
    logic               found_reg, found_next;
    logic               done_reg, done_next;
    lrt_pkg::lrt_rsp_t  rsp_reg, rsp_next;

    logic [CNT_W-1:0]   eff_cap;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ID_BITS-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;

    logic               last;
    logic               match;

    lrt_cfg #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff_cap (eff_cap)
    );

    lrt_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_list (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // rd_data holds the entry at pos_reg while scanning
    assign last  = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);
    assign match = (rd_data == id_reg);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        carry_next = carry_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_reg + AW'(1);
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = carry_reg;

        unique case (state_reg)
            lrt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = req.opcode;
                    id_next    = ID_BITS'(req.item_id);
                    carry_next = ID_BITS'(req.item_id);
                    found_next = 1'b0;
                    pos_next   = '0;
                    if (count_reg == '0)
                    begin
                        state_next = lrt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = lrt_pkg::ST_SCAN;
                    end
                end
            end

            lrt_pkg::ST_SCAN:
            begin
                rd_en    = 1'b1;
                pos_next = pos_reg + AW'(1);
                if (op_reg == lrt_pkg::OP_TOUCH)
                begin
                    // push the carried id in, carry the displaced entry onward
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = carry_reg;
                    carry_next = rd_data;
                    if (match)
                    begin
                        found_next = 1'b1;
                        state_next = lrt_pkg::ST_FINISH;
                    end
                    else if (last)
                    begin
                        state_next = lrt_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    // after the match, move each entry up one slot
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pos_reg - AW'(1);
                        wr_data = rd_data;
                    end
                    found_next = found_reg | match;
                    if (last)
                    begin
                        state_next = lrt_pkg::ST_FINISH;
                    end
                end
            end

            lrt_pkg::ST_FINISH:
            begin
                state_next           = lrt_pkg::ST_IDLE;
                done_next            = 1'b1;
                rsp_next.hit         = found_reg;
                rsp_next.evict_valid = 1'b0;
                rsp_next.evicted_id  = '0;
                if (op_reg == lrt_pkg::OP_TOUCH)
                begin
                    if (!found_reg)
                    begin
                        if ((count_reg >= eff_cap) && (count_reg != '0))
                        begin
                            // drop the tail that fell off the end of the shift
                            rsp_next.evict_valid = 1'b1;
                            rsp_next.evicted_id  = lrt_pkg::id_t'(carry_reg);
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = AW'(count_reg);
                            wr_data    = carry_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else if (found_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                rsp_next.occupancy = lrt_pkg::occ_t'(count_next);
            end

            default:
            begin
                state_next = lrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrt_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        op_reg    <= op_next;
        id_reg    <= id_next;
        carry_reg <= carry_next;
        found_reg <= found_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = (state_reg != lrt_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== hw/rtl/lrt_checker.sv =====
// Port-level checks for the LRU residency tracker, bound to the top level.
module lrt_port_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input lrt_pkg::lrt_rsp_t rsp
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> !rsp.evict_valid)
        else $error("hit reported together with an eviction");

    a_evict_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.evict_valid) |-> (rsp.evicted_id == '0))
        else $error("evicted id nonzero without eviction");

endmodule

bind lru_residency_tracker lrt_port_checks u_port_checks (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ===== test/lrt_checker.sv =====
// Checker for the LRU residency tracker: recency-list predictor and result comparison.
module lrt_checker #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  lrt_pkg::lrt_req_t  req,
    input  logic               done,
    input  lrt_pkg::lrt_rsp_t  rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  lrt_pkg::addr_t     paddr,
    input  lrt_pkg::data_t     pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Front of the list at index 0
    lrt_pkg::id_t      recency [MAX_ENTRIES];
    int                resident;
    lrt_pkg::cap_t     capacity;
    lrt_pkg::lrt_rsp_t awaited_results [$];

    // Apply one request to the tracked list and return the result it produces.
    function automatic lrt_pkg::lrt_rsp_t lru_update(lrt_pkg::lrt_req_t r);
        lrt_pkg::lrt_rsp_t res;
        int                pos;
        int                limit;
        int                p;
        res = '0;
        if (capacity == '0)
            limit = 1;
        else if (int'(capacity) > MAX_ENTRIES)
            limit = MAX_ENTRIES;
        else
            limit = int'(capacity);
        pos = resident;
        for (p = resident - 1; p >= 0; p--)
        begin
            if (recency[p] == r.item_id)
                pos = p;
        end
        res.hit = (pos < resident);
        // Close the gap left by a matching entry
        if (res.hit)
        begin
            for (p = pos; p + 1 < resident; p++)
                recency[p] = recency[p + 1];
            resident--;
        end
        if (r.opcode == lrt_pkg::OP_TOUCH)
        begin
            if (!res.hit && resident >= limit && resident > 0)
            begin
                res.evict_valid = 1'b1;
                res.evicted_id  = recency[resident - 1];
                resident--;
            end
            for (p = resident; p > 0; p--)
                recency[p] = recency[p - 1];
            recency[0] = r.item_id;
            resident++;
        end
        res.occupancy = lrt_pkg::occ_t'(resident);
        return res;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lrt_pkg::lrt_rsp_t want;
        if (!rst_n)
        begin
            resident   = 0;
            capacity   = lrt_pkg::CAP_RESET;
            mismatches = 0;
            awaited_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result transfer with none expected: expected nothing, got %p",
                             $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("hit", 16'(want.hit), 16'(rsp.hit));
                    check_field("evict_valid", 16'(want.evict_valid), 16'(rsp.evict_valid));
                    check_field("evicted_id", 16'(want.evicted_id), 16'(rsp.evicted_id));
                    check_field("occupancy", 16'(want.occupancy), 16'(rsp.occupancy));
                end
            end
            if (start && !busy)
                awaited_results.insert(awaited_results.size(), lru_update(req));
            if (psel && penable && pwrite && pready && paddr == lrt_pkg::CAP_ADDR)
                capacity = pwdata[lrt_pkg::CAP_W-1:0];
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== test/tb_lru_residency_tracker.sv =====
// Testbench top for the LRU residency tracker: stimulus, register writes and verdict.
module tb_lru_residency_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    // Allow generous slack over the worst request, the longest sender gap
    // and a full drain before a register write.
    localparam int MAX_ENTRIES = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * MAX_ENTRIES + 8;
    localparam int PHASES      = 6;
    localparam int MIX_ITEMS   = 40;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    lrt_pkg::lrt_req_t req;
    logic              done;
    lrt_pkg::lrt_rsp_t rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    lrt_pkg::addr_t    paddr;
    lrt_pkg::data_t    pwdata;
    lrt_pkg::data_t    prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;
    int                quiet_cycles = 0;

    lru_residency_tracker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (10)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lrt_checker #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: count cycles in which no request, result or register transfer
    // happens; a hung block trips it long before a correct run goes this quiet.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request and hold it until the block takes it. Called and
    // left at a falling edge, with start still high so back-to-back requests
    // need no extra assignment in between.
    task automatic issue(logic op, lrt_pkg::id_t id);
        logic taken;
        req   <= '{opcode: op, item_id: id};
        start <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
    endtask

    // Idle the request side for a burst of cycles.
    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Drop start and wait until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Write the capacity register with an idle block: setup cycle, then
    // access cycle until pready. Upper data bits are random and must be ignored.
    task automatic write_capacity(lrt_pkg::cap_t value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lrt_pkg::CAP_ADDR;
        pwdata  <= (lrt_pkg::data_t'($urandom) << lrt_pkg::CAP_W) | lrt_pkg::data_t'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        lrt_pkg::cap_t caps [PHASES];
        int            eff;
        int            pool;
        int            pool_base;
        int            sel;
        lrt_pkg::id_t  pick;
        logic          quiet_phase;

        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset capacity: remove on an empty list, ID
        // extremes and alternating bit patterns, hits at the back and front,
        // a remove that finds its entry and one that does not.
        issue(lrt_pkg::OP_REMOVE, lrt_pkg::id_t'(0));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(0));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(10'h3FF));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(10'h155));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(10'h2AA));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(0));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(0));
        issue(lrt_pkg::OP_REMOVE, lrt_pkg::id_t'(10'h3FF));
        issue(lrt_pkg::OP_REMOVE, lrt_pkg::id_t'(10'h3FF));

        // Lower capacity below occupancy: a missing touch evicts one and
        // keeps the count; then evict from a full list of two.
        write_capacity(lrt_pkg::cap_t'(2));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(7));
        issue(lrt_pkg::OP_REMOVE, lrt_pkg::id_t'(7));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(1));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(0));

        // Zero capacity acts as one.
        write_capacity(lrt_pkg::cap_t'(0));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(9));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(0));
        issue(lrt_pkg::OP_REMOVE, lrt_pkg::id_t'(9));
        issue(lrt_pkg::OP_REMOVE, lrt_pkg::id_t'(0));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(5));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(6));

        // Capacity above the list size saturates.
        write_capacity(lrt_pkg::cap_t'(127));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(6));
        issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(10'h200));

        // Random phases. Each starts with a fill run of distinct touches so
        // the list reaches its capacity, then mixes touches and removes over
        // a pool a little larger than the capacity, so hits, misses and
        // evictions all happen; a slice of noise covers every op and ID bit.
        caps[0] = lrt_pkg::cap_t'(64);
        caps[1] = lrt_pkg::cap_t'(1);
        caps[2] = lrt_pkg::cap_t'(127);
        caps[3] = lrt_pkg::cap_t'(0);
        caps[4] = lrt_pkg::cap_t'($urandom_range(2, 16));
        caps[5] = lrt_pkg::cap_t'($urandom_range(0, 127));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_capacity(caps[ph]);
            eff         = (caps[ph] == 0) ? 1 : ((caps[ph] > MAX_ENTRIES) ? MAX_ENTRIES
                                                                          : int'(caps[ph]));
            pool        = eff + 4;
            pool_base   = $urandom_range(0, 1023);
            quiet_phase = (ph == PHASES - 1);

            for (int k = 0; k < eff + MIX_ITEMS; k++)
            begin
                pick = lrt_pkg::id_t'(pool_base + $urandom_range(0, pool - 1));
                sel  = $urandom_range(0, 99);
                if (k < eff)
                    issue(lrt_pkg::OP_TOUCH, lrt_pkg::id_t'(pool_base + k));
                else if (sel < 65)
                    issue(lrt_pkg::OP_TOUCH, pick);
                else if (sel < 85)
                    issue(lrt_pkg::OP_REMOVE, pick);
                else
                    issue(logic'($urandom_range(0, 1)), lrt_pkg::id_t'($urandom));

                // Idle in bursts so gaps land on every scan position; the
                // last phase runs back to back.
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 12));

                // Once per phase but the last, stop and let every result come back.
                if (!quiet_phase && k == eff + MIX_ITEMS / 2)
                    drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
